>>> rtl/core/sbs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted table binary search block
// no dependencies

package sbs_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned IndexW       = 10;
  localparam int unsigned IndexBytesW  = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_RESP
  } state_e;

endpackage

>>> rtl/core/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// sorted table binary search: table memory, search sequencer and result register
// depends on sbs_pkg

// The block keeps a table of signed 32-bit values in one synchronous RAM of
// TABLE_DEPTH entries and answers one item at a time. An item's kind on
// s_axis_tuser_i selects clear (0), append (1) or search (2); code 3 does nothing.
// Every item returns exactly one result item with a status on m_axis_tuser_o
// (0 done or found, 1 not found, 2 table full and append dropped) and the low
// 10 bits of the matching index on m_axis_tdata_o. Clear, append and an
// ignored code go from acceptance straight to S_RESP, where the result is
// loaded into the output register once it is free. A search runs S_READ
// (one RAM read) and S_CMP (compare and bound update) once per probe, at most
// clog2(TABLE_DEPTH) + 1 probes: eleven for 1024 entries, and then S_RESP.
// The probes all go through the single RAM read port; a result still held by
// the output register stalls the sequencer in S_RESP.
// A new item is accepted as soon as the previous one has finished, even while
// its result still waits in the output register. The table must be kept in
// ascending order by the user; an unsorted table still ends every search.
// Entries beyond the fill count are never read, so the RAM needs no clearing.

module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::DefaultDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input item channel
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sbs_pkg::ValueW-1:0]        s_axis_tdata_i,  // [31:0] value
  input  logic [1:0]                        s_axis_tuser_i,  // [1:0] operation
  // result item channel
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sbs_pkg::IndexBytesW-1:0]   m_axis_tdata_o,  // [9:0] found_index, zero pad
  output logic [1:0]                        m_axis_tuser_o   // [1:0] status
);

  import sbs_pkg::*;

  // address and fill count widths follow the table depth
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ExtW  = (AddrW > IndexW) ? AddrW : IndexW;

  // table memory, no reset: only entries below the fill count are read
  logic signed [ValueW-1:0] mem [TABLE_DEPTH];
  logic signed [ValueW-1:0] rdata_q;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [AddrW-1:0]    lo_q, lo_d;
  logic [AddrW-1:0]    hi_q, hi_d;
  logic signed [ValueW-1:0] key_q, key_d;
  status_e             res_status_q, res_status_d;
  logic [IndexW-1:0]   res_index_q, res_index_d;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [IndexW-1:0]   out_index_q;

  logic                s_fire;
  logic                out_load;
  logic                full;
  logic                wr_en;
  logic                rd_en;
  op_e                 op;
  logic [AddrW-1:0]    mid;
  logic [AddrW-1:0]    span;
  logic [ExtW-1:0]     mid_ext;

  assign op     = op_e'(s_axis_tuser_i);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign full   = (count_q == CntW'(TABLE_DEPTH));

  // probe point: low plus half the span, rounded down
  assign span    = hi_q - lo_q;
  assign mid     = lo_q + (span >> 1);
  assign mid_ext = ExtW'(mid);

  // result leaves the sequencer once the output register is free
  assign out_load = (state_q == S_RESP) && (!out_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign wr_en = s_fire && (op == OP_APPEND) && !full;
  assign rd_en = (state_q == S_READ);

  // sequencer: next state and datapath updates
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          res_status_d = ST_OK;
          res_index_d  = '0;
          key_d        = s_axis_tdata_i;
          state_d      = S_RESP;
          case (op)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                count_d = count_q + CntW'(1);
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                lo_d    = '0;
                hi_d    = AddrW'(count_q - CntW'(1));
                state_d = S_READ;
              end
            end
            default: begin
              // unused code: table unchanged, plain done result
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata_q == key_q) begin
          res_index_d = mid_ext[IndexW-1:0];
          state_d     = S_RESP;
        end else if (rdata_q < key_q) begin
          // probe below the key: move low up, span empties at the top bound
          if (mid == hi_q) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_RESP;
          end else begin
            lo_d    = mid + AddrW'(1);
            state_d = S_READ;
          end
        end else begin
          // probe above the key: move high down, span empties at the low bound
          if (mid == lo_q) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_RESP;
          end else begin
            hi_d    = mid - AddrW'(1);
            state_d = S_READ;
          end
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
  end

  // table memory: one write port for appends, one registered read port for probes
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrW-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rdata_q <= mem[mid];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = IndexBytesW'(out_index_q);

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // bounds stay ordered while a search is running
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_CMP) |-> (lo_q <= hi_q))
    else $error("search bounds crossed while probing");

  // a clear empties the table by the next cycle
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && op == OP_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the table");

  // only a found or done result carries a nonzero index
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_index_q == '0))
    else $error("index reported with a failing status");

endmodule

>>> bench/search_result_checker.sv
`timescale 1ns / 1ps
// result checker for the sorted table binary search block: keeps its own table and fill
// count, predicts one result per accepted item and compares it with the result channel
// depends on sbs_pkg

module search_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [sbs_pkg::ValueW-1:0]      s_data_i,
  input  logic [1:0]                      s_user_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [sbs_pkg::IndexBytesW-1:0] m_data_i,
  input  logic [1:0]                      m_user_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     outstanding_o
);

  localparam int unsigned TableDepth = sbs_pkg::DefaultDepth;

  typedef struct packed {
    sbs_pkg::status_e            status;
    logic [sbs_pkg::IndexW-1:0]  index;
  } answer_t;

  logic signed [sbs_pkg::ValueW-1:0] shadow_table [TableDepth];
  logic [10:0]                       shadow_fill = '0;
  answer_t                           pending_answers [$];
  int unsigned                       mismatches = 0;
  int unsigned                       results_seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s, got %0h, want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // apply one item to the shadow table and work out the result it gives
  task automatic apply_table_op(input logic [1:0] op, input logic signed [31:0] key,
                                output answer_t ans);
    int lo;
    int hi;
    int mid;
    bit hit;
    ans.status = sbs_pkg::ST_OK;
    ans.index  = '0;
    case (op)
      sbs_pkg::OP_CLEAR: begin
        shadow_fill = '0;
      end
      sbs_pkg::OP_APPEND: begin
        if (shadow_fill >= TableDepth) begin
          ans.status = sbs_pkg::ST_FULL;
        end else begin
          shadow_table[shadow_fill] = key;
          shadow_fill++;
        end
      end
      sbs_pkg::OP_SEARCH: begin
        lo  = 0;
        hi  = int'(shadow_fill) - 1;
        hit = 1'b0;
        while (!hit && lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_table[mid] == key) begin
            hit       = 1'b1;
            ans.index = mid[sbs_pkg::IndexW-1:0];
          end else if (shadow_table[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (!hit) ans.status = sbs_pkg::ST_NOT_FOUND;
      end
      default: begin
        // unused code leaves the table alone
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want;
    if (!rst_ni) begin
      shadow_fill = '0;
      pending_answers.delete();
    end else begin
      // results first, so a result can never meet an expectation pushed at the same edge
      if (m_valid_i && m_ready_i) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result with no item waiting", 32'(m_user_i), 32'd0);
        end else begin
          want = pending_answers.pop_front();
          if (m_user_i != want.status) begin
            report_mismatch("status", 32'(m_user_i), 32'(want.status));
          end
          if (m_data_i[sbs_pkg::IndexW-1:0] != want.index) begin
            report_mismatch("found_index", 32'(m_data_i[sbs_pkg::IndexW-1:0]),
                            32'(want.index));
          end
          if (m_data_i[sbs_pkg::IndexBytesW-1:sbs_pkg::IndexW] != '0) begin
            report_mismatch("tdata pad", 32'(m_data_i), 32'(want.index));
          end
        end
        results_seen++;
      end
      if (s_valid_i && s_ready_i) begin
        apply_table_op(s_user_i, s_data_i, want);
        pending_answers.push_back(want);
      end
    end
    outstanding_o <= pending_answers.size();
    fail_count_o  <= mismatches;
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// top of the bench for the sorted table binary search block: clock, reset, item
// stimulus, result back-pressure, watchdog and verdict
// depends on sbs_pkg, sorted_table_binary_search and search_result_checker

module testbench;

  import sbs_pkg::*;

  localparam logic [1:0]  OpIgnored   = 2'd3;     // code with no operation behind it
  localparam int unsigned ItemsTarget = 1900;
  localparam int unsigned QuietFrom   = 1650;     // no idling on either side from here on
  localparam int unsigned FullFrom    = 600;      // point where the table gets filled up
  localparam int unsigned StallLimit  = 2000;     // cycles without any handshake
  localparam int unsigned TailCycles  = 40;       // beyond the longest search

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input item channel
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ValueW-1:0]      s_axis_tdata  = '0;
  logic [1:0]             s_axis_tuser  = '0;
  // result item channel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [IndexBytesW-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned items_sent = 0;
  int unsigned gap_odds   = 4;     // sender idles before one item in gap_odds, 0 never
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          quiet = 1'b0;       // set once the run enters its last stretch
  bit          full_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_table_binary_search uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  search_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // result side: random stall bursts, none in the last stretch
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // present one item and hold it until accepted; valid stays high into the next item
  task automatic send_item(input logic [1:0] op, input logic [31:0] val);
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op != OpIgnored) items_sent++;
  endtask

  // drop valid and hold off until every result owed has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // one well-formed run: clear, sorted appends with some noise, then a batch of searches
  task automatic run_episode(input int unsigned n_entries, input bit drain_first);
    longint unsigned step_max;
    longint unsigned room;
    longint unsigned offset;
    longint          cur;
    logic [31:0]     kept [$];
    logic [31:0]     key;
    int unsigned     n_probes;
    int unsigned     kind;
    if (drain_first) wait_drained();
    case ($urandom_range(0, 2))
      0: gap_odds = 0;
      1: gap_odds = 3;
      default: gap_odds = 8;
    endcase
    case ($urandom_range(0, 2))
      0: step_max = 3;                        // many duplicates and neighbors
      1: step_max = 5000;
      default: step_max = 64'h4000_0000;      // spread over the whole range
    endcase
    if (step_max > 64'hFFFF_FFFF / (n_entries + 1)) step_max = 64'hFFFF_FFFF / (n_entries + 1);
    room   = 64'hFFFF_FFFF - step_max * n_entries;
    offset = longint'({32'b0, $urandom}) % (room + 1);
    cur    = longint'(offset) - 64'sd2147483648;
    send_item(OP_CLEAR, $urandom);
    for (int unsigned i = 0; i < n_entries; i++) begin
      kept.push_back(cur[31:0]);
      send_item(OP_APPEND, cur[31:0]);
      cur += $urandom_range(0, int'(step_max));
      // noise: out-of-order append, ignored code, early search, fully random item
      if ($urandom_range(0, 29) == 0) send_item(OP_APPEND, $urandom);
      if ($urandom_range(0, 24) == 0) send_item(OpIgnored, $urandom);
      if ($urandom_range(0, 19) == 0) begin
        send_item(OP_SEARCH, kept[$urandom_range(0, kept.size() - 1)]);
      end
      if ($urandom_range(0, 59) == 0) send_item(2'($urandom_range(0, 3)), $urandom);
    end
    // appends into a full table are dropped
    if (n_entries >= DefaultDepth) begin
      repeat (3) send_item(OP_APPEND, $urandom);
    end
    n_probes = (n_entries >= DefaultDepth) ? 60 : $urandom_range(4, 24);
    repeat (n_probes) begin
      kind = $urandom_range(0, 9);
      if (kind < 6 && kept.size() != 0) begin
        key = kept[$urandom_range(0, kept.size() - 1)];
      end else if (kind < 8 && kept.size() != 0) begin
        key = kept[$urandom_range(0, kept.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      end else if (kind == 9) begin
        key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        key = $urandom;
      end
      send_item(OP_SEARCH, key);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_item(OP_SEARCH, 32'h0000_0000);    // search on empty table
    send_item(OpIgnored, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 32'h8000_0000);    // most negative
    send_item(OP_APPEND, 32'hFFFF_FFFF);    // minus one
    send_item(OP_APPEND, 32'h0000_0000);
    send_item(OP_APPEND, 32'h0000_0001);
    send_item(OP_APPEND, 32'h7FFF_FFFF);    // most positive
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_SEARCH, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'h0000_0002);    // missing, between entries
    send_item(OP_SEARCH, 32'h8000_0001);
    send_item(OpIgnored, 32'h1234_5678);    // must not disturb the table
    send_item(OP_SEARCH, 32'h0000_0001);
    send_item(OP_CLEAR,  32'hA5A5_A5A5);
    send_item(OP_SEARCH, 32'h0000_0000);    // old contents are gone after a clear
    send_item(OP_APPEND, 32'd9);            // unsorted table
    send_item(OP_APPEND, 32'd3);
    send_item(OP_APPEND, 32'd5);
    send_item(OP_SEARCH, 32'd3);
    send_item(OP_SEARCH, 32'd9);
    send_item(OP_APPEND, 32'd5);            // duplicate
    send_item(OP_SEARCH, 32'd5);
    send_item(OP_CLEAR,  32'h0000_0000);

    // random part
    while (items_sent < ItemsTarget) begin
      if (!full_done && items_sent >= FullFrom) begin
        run_episode(DefaultDepth, 1'b1);
        full_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        run_episode($urandom_range(0, 4), $urandom_range(0, 5) == 0);
      end else begin
        run_episode($urandom_range(5, 48), $urandom_range(0, 5) == 0);
      end
      if (items_sent >= QuietFrom) quiet <= 1'b1;
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sbs_pkg.sv
rtl/core/sorted_table_binary_search.sv
bench/search_result_checker.sv
bench/testbench.sv
